[hdl/emst_pkg.sv]
// Package with shared types and constants for the spanning tree core.
`default_nettype none
package emst_pkg;
  localparam int CoordW = 29;
  localparam int IdxW   = 6;
  localparam int LenW   = 58;
  localparam int DiffW  = 30;
  localparam int SqW    = 60;
  localparam int ResultCap = 63;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_RD,
    ST_MUL,
    ST_SUM,
    ST_CMP,
    ST_MERGE_RD,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic hold;
  } mul_ctl_t;
endpackage
`default_nettype wire

[hdl/emst_sqdist.sv]
// Shared squared distance unit: abs diff, square, sum over three steps.
`default_nettype none
module emst_sqdist
  import emst_pkg::*;
(
  input  wire logic                     clk,
  input  wire mul_ctl_t                 ctl,
  input  wire logic signed [CoordW-1:0] xa,
  input  wire logic signed [CoordW-1:0] xb,
  input  wire logic signed [CoordW-1:0] ya,
  input  wire logic signed [CoordW-1:0] yb,
  output logic             [SqW-1:0]    sq_len
);
  logic [DiffW-1:0] dx_r, dy_r;
  logic [SqW-1:0]   sx_r, sy_r;
  logic signed [DiffW-1:0] ddx, ddy;

  always_comb begin
    ddx = DiffW'(xa) - DiffW'(xb);
    ddy = DiffW'(ya) - DiffW'(yb);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dx_r <= ddx[DiffW-1] ? DiffW'(-ddx) : DiffW'(ddx);
      dy_r <= ddy[DiffW-1] ? DiffW'(-ddy) : DiffW'(ddy);
    end
    if (!ctl.hold) begin
      sx_r <= dx_r * dx_r;
      sy_r <= dy_r * dy_r;
    end
  end

  assign sq_len = sx_r + sy_r;
endmodule
`default_nettype wire

[hdl/euclidean_min_spanning_tree_core.sv]
// Top level of the Euclidean minimum spanning tree core.
// Points load one per beat while busy is low; a beat with in_last_point starts the
// tree search when two or more points are held (else the set is dropped), and busy
// stays high until all edges are sent. Each edge costs one full pair scan through
// the shared distance unit plus a label merge. Edges appear one per out_valid pulse
// and cannot be stalled.
`default_nettype none
module euclidean_min_spanning_tree_core
  import emst_pkg::*;
#(
  parameter int MAX_POINTS = 64
)(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [CoordW-1:0] in_point_x,
  input  wire logic signed [CoordW-1:0] in_point_y,
  input  wire logic                     in_last_point,
  output logic                          out_valid,
  output logic             [IdxW-1:0]   out_edge_first,
  output logic             [IdxW-1:0]   out_edge_second,
  output logic             [LenW-1:0]   out_squared_length,
  output logic                          out_last_edge
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = AW + 1;

  logic signed [CoordW-1:0] xs [MAX_POINTS];
  logic signed [CoordW-1:0] ys [MAX_POINTS];
  logic        [AW-1:0]     lab [MAX_POINTS];

  state_t st_r, st_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, bi_r, bi_nxt, bj_r, bj_nxt;
  logic [CW-1:0] k_r, k_nxt, total_r, total_nxt;
  logic          have_r, have_nxt;
  logic [SqW-1:0] best_r, best_nxt;
  logic [AW-1:0] from_r, to_r;
  logic [AW-1:0] mi_r;
  logic signed [CoordW-1:0] xa_r, xb_r, ya_r, yb_r;
  logic [AW-1:0] la_r, lb_r;
  logic [SqW-1:0] sq_len;
  mul_ctl_t ctl;
  logic accept;

  assign accept = start && !busy;
  assign busy = (st_r != ST_LOAD);

  always_comb begin
    ctl.start = (st_r == ST_MUL);
    ctl.hold  = (st_r != ST_SUM);
  end

  emst_sqdist u_sq (
    .clk(clk), .ctl(ctl), .xa(xa_r), .xb(xb_r), .ya(ya_r), .yb(yb_r), .sq_len(sq_len)
  );

  // memories
  always_ff @(posedge clk) begin
    if (st_r == ST_LOAD && accept && n_r < CW'(MAX_POINTS)) begin
      xs[n_r[AW-1:0]] <= in_point_x;
      ys[n_r[AW-1:0]] <= in_point_y;
    end
    if (st_r == ST_INIT) lab[i_r] <= i_r;
    if (st_r == ST_MERGE && la_r == from_r) lab[mi_r] <= to_r;
    xa_r <= xs[i_r];
    ya_r <= ys[i_r];
    xb_r <= xs[j_r];
    yb_r <= ys[j_r];
    la_r <= lab[i_r];
    lb_r <= lab[j_r];
  end

  always_comb begin
    st_nxt = st_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; bi_nxt = bi_r; bj_nxt = bj_r;
    k_nxt = k_r; total_nxt = total_r; have_nxt = have_r; best_nxt = best_r;
    unique case (st_r)
      ST_LOAD: begin
        if (accept) begin
          if (n_r < CW'(MAX_POINTS)) n_nxt = n_r + 1'b1;
          if (in_last_point) begin
            if (n_nxt < 2) n_nxt = '0;
            else begin
              st_nxt = ST_INIT;
              i_nxt = '0;
              k_nxt = '0;
              total_nxt = (n_nxt - 1'b1 > CW'(ResultCap)) ? CW'(ResultCap)
                                                         : n_nxt - 1'b1;
            end
          end
        end
      end
      ST_INIT: begin
        if ({1'b0, i_r} == n_r - 1'b1) begin
          st_nxt = ST_RD; i_nxt = '0; j_nxt = AW'(1); have_nxt = 1'b0;
        end else i_nxt = i_r + 1'b1;
      end
      ST_RD: st_nxt = ST_MUL;
      ST_MUL: st_nxt = (la_r == lb_r) ? ST_CMP : ST_SUM;
      ST_SUM: st_nxt = ST_CMP;
      ST_CMP: begin
        if (la_r != lb_r && (!have_r || sq_len < best_r)) begin
          have_nxt = 1'b1; best_nxt = sq_len; bi_nxt = i_r; bj_nxt = j_r;
        end
        st_nxt = ST_RD;
        if ({1'b0, j_r} == n_r - 1'b1) begin
          if ({1'b0, i_r} == n_r - CW'(2)) begin
            st_nxt = ST_MERGE_RD; i_nxt = bi_nxt; j_nxt = bj_nxt;
          end else begin
            i_nxt = i_r + 1'b1; j_nxt = i_r + AW'(2);
          end
        end else j_nxt = j_r + 1'b1;
      end
      ST_MERGE_RD: begin
        st_nxt = ST_EMIT; i_nxt = '0;
      end
      ST_EMIT: st_nxt = ST_MERGE;
      ST_MERGE: begin
        if ({1'b0, i_r} != n_r - 1'b1) i_nxt = i_r + 1'b1;
        if ({1'b0, mi_r} == n_r - 1'b1) begin
          k_nxt = k_r + 1'b1;
          if (k_nxt == total_r) begin
            st_nxt = ST_LOAD; n_nxt = '0;
          end else begin
            st_nxt = ST_RD; i_nxt = '0; j_nxt = AW'(1); have_nxt = 1'b0;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // merge reads label of i in the prior cycle; write back at the delayed index
  always_ff @(posedge clk) begin
    if (st_r == ST_EMIT) begin
      from_r <= la_r;
      to_r   <= lb_r;
    end
    mi_r <= i_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; n_r <= '0; k_r <= '0; have_r <= 1'b0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; k_r <= k_nxt; have_r <= have_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; bi_r <= bi_nxt; bj_r <= bj_nxt;
    total_r <= total_nxt; best_r <= best_nxt;
  end

  always_comb begin
    out_valid = (st_r == ST_EMIT);
    out_edge_first = IdxW'(bi_r);
    out_edge_second = IdxW'(bj_r);
    out_squared_length = (best_r > SqW'({LenW{1'b1}})) ? {LenW{1'b1}} : best_r[LenW-1:0];
    out_last_edge = (k_r + 1'b1 == total_r);
  end

`ifndef SYNTHESIS
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("edge outside busy");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_first < out_edge_second) else $error("edge order");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_edge |-> ##[0:0] 1'b1 ##1 !out_valid) else $error("last");
  a_mi: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MERGE && $past(st_r) == ST_MERGE |-> mi_r + 1'b1 == i_r || mi_r == i_r)
    else $error("merge walk");
`endif
endmodule
`default_nettype wire

[verif/euclidean_min_spanning_tree_core_tb.sv]
// Testbench for the spanning tree core: directed and random point sets checked edge by edge.
`timescale 1ns / 1ps
module euclidean_min_spanning_tree_core_tb;
  import emst_pkg::*;

  localparam int Capacity = 64;
  localparam int IdleLimit = 200000;
  localparam longint unsigned LenMax = (64'd1 << LenW) - 64'd1;

  typedef struct {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] second;
    logic [LenW-1:0] length;
    logic            last;
  } tree_edge_t;

  class tree_scoreboard;
    longint xs[Capacity];
    longint ys[Capacity];
    int held;
    int errors;
    tree_edge_t edges_due[$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    function longint unsigned dist2(int i, int j);
      longint dx;
      longint dy;
      dx = xs[i] - xs[j];
      dy = ys[i] - ys[j];
      return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // store a beat; on the final point build the tree in Kruskal order
    function void note_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic last);
      int lab[Capacity];
      int n;
      int total;
      int bi;
      int bj;
      int from;
      int to;
      bit have;
      longint unsigned best;
      longint unsigned d;
      tree_edge_t e;
      if (held < Capacity) begin
        xs[held] = x;
        ys[held] = y;
        held++;
      end
      if (!last) return;
      n = held;
      held = 0;
      if (n < 2) return;
      for (int i = 0; i < n; i++) lab[i] = i;
      total = (n - 1 > ResultCap) ? ResultCap : n - 1;
      for (int k = 0; k < total; k++) begin
        have = 0;
        best = 0;
        bi = 0;
        bj = 0;
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            if (lab[i] != lab[j]) begin
              d = dist2(i, j);
              if (!have || d < best) begin
                have = 1;
                best = d;
                bi = i;
                bj = j;
              end
            end
          end
        end
        from = lab[bi];
        to = lab[bj];
        for (int i = 0; i < n; i++) if (lab[i] == from) lab[i] = to;
        e.first = bi[IdxW-1:0];
        e.second = bj[IdxW-1:0];
        e.length = (best > LenMax) ? LenMax[LenW-1:0] : best[LenW-1:0];
        e.last = (k + 1 == total);
        edges_due = {edges_due, e};
      end
    endfunction

    function void check_edge(logic [IdxW-1:0] first, logic [IdxW-1:0] second,
                             logic [LenW-1:0] length, logic last);
      tree_edge_t e;
      if (edges_due.size() == 0) begin
        $display("%0t: unexpected edge %0d-%0d len %0d", $time, first, second, length);
        errors++;
        return;
      end
      e = edges_due.pop_front();
      if (first !== e.first) begin
        $display("%0t: edge_first exp %0d got %0d", $time, e.first, first);
        errors++;
      end
      if (second !== e.second) begin
        $display("%0t: edge_second exp %0d got %0d", $time, e.second, second);
        errors++;
      end
      if (length !== e.length) begin
        $display("%0t: squared_length exp %0d got %0d", $time, e.length, length);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_edge exp %0d got %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] in_point_x;
  logic signed [CoordW-1:0] in_point_y;
  logic in_last_point;
  logic out_valid;
  logic [IdxW-1:0] out_edge_first;
  logic [IdxW-1:0] out_edge_second;
  logic [LenW-1:0] out_squared_length;
  logic out_last_edge;

  tree_scoreboard sb;
  int idle_cycles;
  int burst_left;
  int points_sent;

  euclidean_min_spanning_tree_core #(.MAX_POINTS(Capacity)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_last_point(in_last_point),
    .out_valid(out_valid),
    .out_edge_first(out_edge_first),
    .out_edge_second(out_edge_second),
    .out_squared_length(out_squared_length),
    .out_last_edge(out_last_edge)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_point(in_point_x, in_point_y, in_last_point);
      if (out_valid)
        sb.check_edge(out_edge_first, out_edge_second, out_squared_length, out_last_edge);
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // drive one beat at the falling edge, with idle gaps between bursts
  task automatic send_point(input logic signed [CoordW-1:0] x,
                            input logic signed [CoordW-1:0] y, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start = 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    start = 1;
    in_point_x = x;
    in_point_y = y;
    in_last_point = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
    points_sent++;
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom_range(0, 20)) - CoordW'(10);
      1: return CoordW'($urandom);
      default: return CoordW'(int'($urandom_range(0, 360000000)) - 180000000);
    endcase
  endfunction

  task automatic send_set(input int n, input int mode);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    burst_left = 0;
    points_sent = 0;
    start = 0;
    in_point_x = '0;
    in_point_y = '0;
    in_last_point = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_point(29'sd5, -29'sd5, 1'b1);
    send_point(-29'sd180000000, -29'sd180000000, 1'b0);
    send_point(29'sd180000000, 29'sd180000000, 1'b1);
    send_point({1'b1, {(CoordW-1){1'b0}}}, {1'b1, {(CoordW-1){1'b0}}}, 1'b0);
    send_point({1'b0, {(CoordW-1){1'b1}}}, {1'b0, {(CoordW-1){1'b1}}}, 1'b1);
    send_point(29'sd0, 29'sd0, 1'b0);
    send_point(29'sd10, 29'sd0, 1'b0);
    send_point(29'sd0, 29'sd10, 1'b0);
    send_point(29'sd10, 29'sd10, 1'b0);
    send_point(29'sd0, 29'sd0, 1'b0);
    send_point(-29'sd1, 29'sd0, 1'b1);

    // overflow: two beats past capacity, the final one still closes the set
    send_set(Capacity + 2, 2);

    while (points_sent < 150) begin
      case ($urandom_range(0, 9))
        0: send_set(1, $urandom_range(0, 2));
        1, 2: send_set($urandom_range(2, 8), 0);
        3, 4: send_set($urandom_range(2, 8), 1);
        default: send_set($urandom_range(2, 10), 2);
      endcase
    end
    start = 0;
    in_last_point = 0;

    while (sb.edges_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[euclidean_min_spanning_tree_core.f]
hdl/emst_pkg.sv
hdl/emst_sqdist.sv
hdl/euclidean_min_spanning_tree_core.sv
verif/euclidean_min_spanning_tree_core_tb.sv
